// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file; they compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_CHECK(label, clk, rst, prop, msg)

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/petm_pkg.sv =====
// Shared types and constants of the pixel edge threshold map.
`default_nettype none

package petm_pkg;

   localparam int FRAME_WIDTH = 88;
   localparam int FRAME_HEIGHT = 72;
   localparam int PIXEL_WIDTH = 8;
   localparam int COORD_WIDTH = 10;
   localparam int LINE_ADDR_WIDTH = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;

   localparam logic [COORD_WIDTH-1:0] LAST_COLUMN = COORD_WIDTH'(FRAME_WIDTH - 1);
   localparam logic [COORD_WIDTH-1:0] LAST_ROW = COORD_WIDTH'(FRAME_HEIGHT - 1);

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_value;
      logic                   frame_start;
   } pixel_req_type;

   typedef struct packed {
      logic                   edge_mark;
      logic [COORD_WIDTH-1:0] column;
      logic [COORD_WIDTH-1:0] row;
      logic                   frame_end;
   } edge_rsp_type;

   typedef struct packed {
      logic                       en;
      logic [LINE_ADDR_WIDTH-1:0] addr;
      logic [PIXEL_WIDTH-1:0]     data;
   } line_wr_type;

endpackage

`default_nettype wire

// ===== rtl/petm_line_buf.sv =====
// One-row line buffer with registered read and write-to-read forwarding.
`default_nettype none

module petm_line_buf (
   input  wire logic                                clock,
   input  wire logic                                rd_en,
   input  wire logic [petm_pkg::LINE_ADDR_WIDTH-1:0] rd_addr,
   input  wire petm_pkg::line_wr_type               wr,
   output logic [petm_pkg::PIXEL_WIDTH-1:0]         rd_data
);

   logic [petm_pkg::PIXEL_WIDTH-1:0] line_store_ff [petm_pkg::FRAME_WIDTH];
   logic [petm_pkg::PIXEL_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_store_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= line_store_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pixel_edge_threshold_map.sv =====
// Top level: gradient threshold edge map over a raster pixel stream.
// Accepted requests pass the pixel stage register, then the result register.
// One request per cycle unless rsp_stall blocks; line read and write share one cycle.
// A request that takes the first row or column gives no result but still updates state.
// Synchronous active-high reset clears valids, position counters, the threshold and
// the left and upper-left pixels; line buffer contents are not cleared by reset.
`default_nettype none

module pixel_edge_threshold_map (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire petm_pkg::pixel_req_type         req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output petm_pkg::edge_rsp_type               rsp_data,
   input  wire logic                            csr_write_enable,
   input  wire logic [petm_pkg::PIXEL_WIDTH-1:0] csr_write_data
);

   `include "assert_macros.svh"

   logic [petm_pkg::PIXEL_WIDTH-1:0] threshold_ff;
   logic [petm_pkg::COORD_WIDTH-1:0] col_ff, col_in, row_ff, row_in;
   logic [petm_pkg::COORD_WIDTH-1:0] cur_col, cur_row;

   logic                             s1_valid_ff, s1_valid_in;
   logic [petm_pkg::PIXEL_WIDTH-1:0] s1_pixel_ff;
   logic [petm_pkg::COORD_WIDTH-1:0] s1_col_ff, s1_row_ff;

   logic [petm_pkg::PIXEL_WIDTH-1:0] left_ff, upper_left_ff;
   logic [petm_pkg::PIXEL_WIDTH-1:0] above;

   logic                             rsp_valid_ff, rsp_valid_in;
   petm_pkg::edge_rsp_type           rsp_data_ff, rsp_data_in;

   logic                             req_accept;
   logic                             s1_adv;
   logic                             judged;
   petm_pkg::line_wr_type            line_wr;

   function automatic logic differs(input logic [petm_pkg::PIXEL_WIDTH-1:0] a,
                                    input logic [petm_pkg::PIXEL_WIDTH-1:0] b,
                                    input logic [petm_pkg::PIXEL_WIDTH-1:0] thr);
      logic [petm_pkg::PIXEL_WIDTH-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d > thr;
   endfunction

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   assign cur_col = req_data.frame_start ? '0 : col_ff;
   assign cur_row = req_data.frame_start ? '0 : row_ff;

   assign line_wr.en = s1_adv;
   assign line_wr.addr = s1_col_ff[petm_pkg::LINE_ADDR_WIDTH-1:0];
   assign line_wr.data = s1_pixel_ff;

   petm_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (cur_col[petm_pkg::LINE_ADDR_WIDTH-1:0]),
      .wr      (line_wr),
      .rd_data (above)
   );

   assign judged = (s1_col_ff != '0) && (s1_row_ff != '0);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (cur_col == petm_pkg::LAST_COLUMN) begin
            col_in = '0;
            row_in = (cur_row == petm_pkg::LAST_ROW) ? '0 : cur_row + 1'b1;
         end else begin
            col_in = cur_col + 1'b1;
            row_in = cur_row;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_adv;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_adv) begin
         rsp_valid_in = judged;
      end
      rsp_data_in.edge_mark = differs(upper_left_ff, above, threshold_ff) ||
                              differs(upper_left_ff, left_ff, threshold_ff);
      rsp_data_in.column = s1_col_ff - 1'b1;
      rsp_data_in.row = s1_row_ff - 1'b1;
      rsp_data_in.frame_end = (s1_col_ff == petm_pkg::LAST_COLUMN) &&
                              (s1_row_ff == petm_pkg::LAST_ROW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff <= '0;
         upper_left_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            threshold_ff <= csr_write_data;
         end
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            left_ff <= s1_pixel_ff;
            upper_left_ff <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_data.pixel_value;
         s1_col_ff <= cur_col;
         s1_row_ff <= cur_row;
      end
      if (s1_adv && judged) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `ASSERT_IMPLY(a_frame_end_pos, clock, reset,
      rsp_valid_ff && rsp_data_ff.frame_end,
      (rsp_data_ff.column == petm_pkg::LAST_COLUMN - 1'b1) &&
      (rsp_data_ff.row == petm_pkg::LAST_ROW - 1'b1),
      "frame end flagged away from the last judged position")
   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, s1_valid_ff,
      "accepted request did not reach the pixel stage")
   `ASSERT_NEXT(a_frame_start_origin, clock, reset, req_accept && req_data.frame_start,
      (s1_col_ff == '0) && (s1_row_ff == '0),
      "frame start did not place the pixel at the origin")
   `ASSERT_IMPLY(a_stall_needs_stage, clock, reset, req_stall,
      s1_valid_ff && rsp_valid_ff && rsp_stall,
      "request stalled without a blocked pixel stage")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pixel edge threshold map.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned BLOCK_COUNT = 9;
   localparam int unsigned FRAGMENT_QUOTA = 120;

   typedef struct {
      int unsigned                      count;
      logic [petm_pkg::PIXEL_WIDTH-1:0] pixel;
      logic                             start;
      int                               mark;
   } pixel_run_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   petm_pkg::pixel_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   petm_pkg::edge_rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [petm_pkg::PIXEL_WIDTH-1:0] csr_write_data = '0;

   petm_pkg::edge_rsp_type pending_edges[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit hold_request = 1'b0;
   bit hold_served = 1'b0;
   int unsigned hold_left = 0;

   logic [petm_pkg::PIXEL_WIDTH-1:0] line_copy [petm_pkg::FRAME_WIDTH] = '{default: 8'h00};
   logic [petm_pkg::PIXEL_WIDTH-1:0] left_copy = 8'h00;
   logic [petm_pkg::PIXEL_WIDTH-1:0] upper_left_copy = 8'h00;
   logic [petm_pkg::PIXEL_WIDTH-1:0] threshold_copy = 8'h00;
   int unsigned map_column = 0;
   int unsigned map_row = 0;

   // Rows are runs of equal pixels; the frame start flag applies to the first pixel only.
   pixel_run_type directed_runs [7] = '{
      '{88, 8'h00, 1'b1, -1},
      '{88, 8'hFF, 1'b0, 1},
      '{88, 8'hFF, 1'b0, 0},
      '{1, 8'h80, 1'b1, -1},
      '{87, 8'h80, 1'b0, -1},
      '{88, 8'h7F, 1'b0, 1},
      '{88, 8'h7F, 1'b0, 0}
   };

   pixel_edge_threshold_map u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit over_threshold(input logic [petm_pkg::PIXEL_WIDTH-1:0] a,
                                         input logic [petm_pkg::PIXEL_WIDTH-1:0] b);
      logic [petm_pkg::PIXEL_WIDTH-1:0] gap;
      gap = (a > b) ? a - b : b - a;
      return gap > threshold_copy;
   endfunction

   task automatic advance_edge_map(input petm_pkg::pixel_req_type req, output bit produced,
                                   output petm_pkg::edge_rsp_type want);
      int unsigned x;
      int unsigned y;
      logic [petm_pkg::PIXEL_WIDTH-1:0] above;
      if (req.frame_start) begin
         map_column = 0;
         map_row = 0;
      end
      x = (map_column >= petm_pkg::FRAME_WIDTH) ? 0 : map_column;
      y = (map_row >= petm_pkg::FRAME_HEIGHT) ? 0 : map_row;
      above = line_copy[x];
      produced = (x >= 1) && (y >= 1);
      want.edge_mark = over_threshold(upper_left_copy, above) ||
                       over_threshold(upper_left_copy, left_copy);
      want.column = petm_pkg::COORD_WIDTH'(x - 1);
      want.row = petm_pkg::COORD_WIDTH'(y - 1);
      want.frame_end = (x == petm_pkg::FRAME_WIDTH - 1) && (y == petm_pkg::FRAME_HEIGHT - 1);
      upper_left_copy = above;
      line_copy[x] = req.pixel_value;
      left_copy = req.pixel_value;
      if (x + 1 >= petm_pkg::FRAME_WIDTH) begin
         map_column = 0;
         map_row = (y + 1 >= petm_pkg::FRAME_HEIGHT) ? 0 : y + 1;
      end else begin
         map_column = x + 1;
         map_row = y;
      end
   endtask

   function automatic logic [petm_pkg::PIXEL_WIDTH-1:0] next_pixel(
      input logic [petm_pkg::PIXEL_WIDTH-1:0] prev);
      int level;
      case ($urandom_range(0, 9))
         0: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         1, 2: return petm_pkg::PIXEL_WIDTH'($urandom_range(0, 255));
         default: begin
            level = int'(prev) + int'($urandom_range(0, 24)) - 12;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            return petm_pkg::PIXEL_WIDTH'(level);
         end
      endcase
   endfunction

   task automatic offer_pixel(input logic [petm_pkg::PIXEL_WIDTH-1:0] pix, input logic start,
                              input int typed_mark);
      petm_pkg::pixel_req_type req;
      petm_pkg::edge_rsp_type want;
      bit produced;
      req.pixel_value = pix;
      req.frame_start = start;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_edge_map(req, produced, want);
      if (produced) begin
         if (typed_mark >= 0) want.edge_mark = typed_mark[0];
         pending_edges.push_back(want);
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [petm_pkg::PIXEL_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      threshold_copy = value;
   endtask

   task automatic run_fragments(input int unsigned quota);
      int unsigned sent;
      int unsigned span;
      int unsigned k;
      logic [petm_pkg::PIXEL_WIDTH-1:0] pix;
      logic start;
      sent = 0;
      pix = petm_pkg::PIXEL_WIDTH'($urandom_range(0, 255));
      while (sent < quota) begin
         if ($urandom_range(0, 9) < 2) span = $urandom_range(1, 100);
         else span = $urandom_range(120, 300);
         if (span > quota - sent) span = quota - sent;
         for (k = 0; k < span; k++) begin
            pix = next_pixel(pix);
            if (k == 0) start = ($urandom_range(0, 9) != 0);
            else start = ($urandom_range(0, 299) == 0);
            offer_pixel(pix, start, -1);
         end
         sent += span;
      end
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         hold_served <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      petm_pkg::edge_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_edges.size() == 0) begin
            $error("unexpected result: column %0d row %0d", rsp_data.column, rsp_data.row);
            mismatch_count++;
         end else begin
            want = pending_edges.pop_front();
            if (rsp_data.edge_mark !== want.edge_mark) begin
               $error("edge_mark: expected %0d, got %0d", want.edge_mark, rsp_data.edge_mark);
               mismatch_count++;
            end
            if (rsp_data.column !== want.column) begin
               $error("column: expected %0d, got %0d", want.column, rsp_data.column);
               mismatch_count++;
            end
            if (rsp_data.row !== want.row) begin
               $error("row: expected %0d, got %0d", want.row, rsp_data.row);
               mismatch_count++;
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_data.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned r;
      int unsigned k;
      int unsigned b;
      logic [petm_pkg::PIXEL_WIDTH-1:0] block_threshold [BLOCK_COUNT];
      block_threshold[0] = petm_pkg::PIXEL_WIDTH'($urandom_range(1, 30));
      block_threshold[1] = 8'hFF;
      block_threshold[2] = petm_pkg::PIXEL_WIDTH'($urandom_range(0, 254));
      block_threshold[3] = 8'h00;
      block_threshold[4] = petm_pkg::PIXEL_WIDTH'($urandom_range(1, 32));
      block_threshold[5] = 8'hFE;
      block_threshold[6] = petm_pkg::PIXEL_WIDTH'($urandom_range(0, 16));
      block_threshold[7] = petm_pkg::PIXEL_WIDTH'($urandom_range(0, 24));
      block_threshold[8] = petm_pkg::PIXEL_WIDTH'($urandom_range(0, 12));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_threshold(8'h00);

      for (r = 0; r < $size(directed_runs); r++) begin
         for (k = 0; k < directed_runs[r].count; k++) begin
            offer_pixel(directed_runs[r].pixel, directed_runs[r].start && (k == 0),
                        directed_runs[r].mark);
         end
      end
      settle_block();

      for (b = 0; b < BLOCK_COUNT; b++) begin
         case (b / 3)
            0: begin
               send_gap_pct = 31;
               recv_stall_pct = 71;
            end
            1: begin
               send_gap_pct = 71;
               recv_stall_pct = 31;
            end
            default: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         write_threshold(block_threshold[b]);
         if (b == 6) hold_request = 1'b1;
         run_fragments(FRAGMENT_QUOTA);
         settle_block();
      end

      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
